/* hw/rtl/crt_pkg.sv */
// Shared types and codes for the coalescing request table.
// Used by crt_seq and coalescing_request_table_top; depends on nothing.
`default_nettype none

package crt_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned CNT_W = 7;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 7'd64;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_DRAIN   = 2'd2,
    OP_READ    = 2'd3
  } crt_op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [1:0] CFG_ACTIVE_SLOTS = 2'd0;
  localparam logic [1:0] CFG_GRID_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_GRID_DEPTH   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_COUNT,
    S_DSCAN,
    S_DREAD,
    S_EMIT
  } crt_state_t;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key_x;
    logic signed [KEY_W-1:0] key_z;
    logic [CNT_W-1:0]        drain_limit;
  } crt_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_x;
    logic signed [KEY_W-1:0] out_z;
    logic                    key_present;
    logic                    last;
    logic [6:0]              pending_total;
    logic [31:0]             queued_total;
    logic [31:0]             coalesced_total;
    logic [31:0]             dropped_total;
  } crt_out_t;

  typedef struct packed {
    logic [6:0]  active_slots;
    logic [14:0] grid_width;
    logic [14:0] grid_depth;
  } crt_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/coalescing_request_table_top.sv */
// Top level of the coalescing request table: config registers, sequencer, key store.
// Depends on crt_pkg, crt_seq and crt_ram.
//
// One input beat is handled at a time and the input stalls until its last result is
// in the output register; a waiting result does not hold off the next beat. All work
// goes through one slot-scan sequencer with a single compare unit and a key store RAM
// with registered read. A valid request or a remove walks slots 0 to limit-1, reading
// and comparing the key of each busy slot, stopping early on a match. A drain first
// counts busy slots at one a cycle, up to its limit, then scans again, reading and
// emitting each busy slot's key until the counted keys are out. Counter reads and
// refused beats go straight to the result without a scan.
`default_nettype none

module coalescing_request_table_top
  import crt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 64,
  parameter int unsigned COORD_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data,
  input  wire logic        in_valid,
  input  wire crt_in_t     in_data,
  output logic             in_stall,
  output logic             out_valid,
  output crt_out_t         out_data,
  input  wire logic        out_stall
);

  localparam int unsigned AW = TABLE_SLOTS > 1 ? $clog2(TABLE_SLOTS) : 1;

  crt_cfg_t cfg_r;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [2*COORD_BITS-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_slots <= 7'd64;
      cfg_r.grid_width   <= 15'd256;
      cfg_r.grid_depth   <= 15'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_SLOTS: cfg_r.active_slots <= cfg_data[6:0];
        CFG_GRID_WIDTH:   cfg_r.grid_width   <= cfg_data;
        CFG_GRID_DEPTH:   cfg_r.grid_depth   <= cfg_data;
        default: ;
      endcase
    end
  end

  crt_seq #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  crt_ram #(
    .WIDTH(2 * COORD_BITS),
    .DEPTH(TABLE_SLOTS)
  ) u_keys (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/crt_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module crt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/crt_seq.sv */
// Slot scan sequencer: busy flags, counters, compare unit and result register.
// Depends on crt_pkg; drives the key store RAM in the top level.
`default_nettype none

module crt_seq
  import crt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 64,
  parameter int unsigned COORD_BITS  = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire crt_cfg_t                                      cfg,
  input  wire logic                                          in_valid,
  input  wire crt_in_t                                       in_data,
  output logic                                               in_stall,
  output logic                                               out_valid,
  output crt_out_t                                           out_data,
  input  wire logic                                          out_stall,
  output logic                                               ram_we,
  output logic [(TABLE_SLOTS > 1 ? $clog2(TABLE_SLOTS) : 1)-1:0] ram_waddr,
  output logic [2*COORD_BITS-1:0]                            ram_wdata,
  output logic                                               ram_re,
  output logic [(TABLE_SLOTS > 1 ? $clog2(TABLE_SLOTS) : 1)-1:0] ram_raddr,
  input  wire logic [2*COORD_BITS-1:0]                       ram_rdata
);

  localparam int unsigned AW = TABLE_SLOTS > 1 ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned SW = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned CB = COORD_BITS;

  function automatic logic [KEY_W-1:0] coord_out(input logic [CB-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    for (int b = 0; b < 32; b++) begin
      if (b >= CB && CB < KEY_W) begin
        e[b] = v[CB-1];
      end
    end
    return e[KEY_W-1:0];
  endfunction

  crt_state_t       state_r, state_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [CB-1:0]    kx_r, kx_nxt, kz_r, kz_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic             free_found_r, free_found_nxt;
  logic [AW-1:0]    free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, em_r, em_nxt;
  logic [SW-1:0]    pending_r, pending_nxt;
  logic [31:0]      queued_r, queued_nxt, coal_r, coal_nxt, drop_r, drop_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [KEY_W-1:0] res_x_r, res_x_nxt, res_z_r, res_z_nxt;
  logic             res_present_r, res_present_nxt, res_last_r, res_last_nxt;
  logic [TABLE_SLOTS-1:0] busy_r, busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  crt_out_t         out_data_r, out_data_nxt;

  logic [SW-1:0]    lim;
  logic [AW-1:0]    slot;
  logic             key_bad;

  assign lim = (int'(cfg.active_slots) > TABLE_SLOTS) ? SW'(TABLE_SLOTS)
                                                      : SW'(cfg.active_slots);
  assign slot = idx_r[AW-1:0];
  assign key_bad = in_data.key_x[KEY_W-1] || in_data.key_z[KEY_W-1] ||
                   (in_data.key_x[14:0] >= cfg.grid_width) ||
                   (in_data.key_z[14:0] >= cfg.grid_depth);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      pending_r   <= '0;
      queued_r    <= '0;
      coal_r      <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      pending_r   <= pending_nxt;
      queued_r    <= queued_nxt;
      coal_r      <= coal_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    op_r          <= op_nxt;
    kx_r          <= kx_nxt;
    kz_r          <= kz_nxt;
    cap_r         <= cap_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    cnt_r         <= cnt_nxt;
    em_r          <= em_nxt;
    res_status_r  <= res_status_nxt;
    res_x_r       <= res_x_nxt;
    res_z_r       <= res_z_nxt;
    res_present_r <= res_present_nxt;
    res_last_r    <= res_last_nxt;
    out_data_r    <= out_data_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    op_nxt          = op_r;
    kx_nxt          = kx_r;
    kz_nxt          = kz_r;
    cap_nxt         = cap_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    cnt_nxt         = cnt_r;
    em_nxt          = em_r;
    pending_nxt     = pending_r;
    queued_nxt      = queued_r;
    coal_nxt        = coal_r;
    drop_nxt        = drop_r;
    res_status_nxt  = res_status_r;
    res_x_nxt       = res_x_r;
    res_z_nxt       = res_z_r;
    res_present_nxt = res_present_r;
    res_last_nxt    = res_last_r;
    busy_nxt        = busy_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    ram_we          = 1'b0;
    ram_waddr       = free_idx_r;
    ram_wdata       = {kx_r, kz_r};
    ram_re          = 1'b0;
    ram_raddr       = slot;
    in_stall        = (state_r != S_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt          = in_data.op;
          kx_nxt          = CB'($unsigned(in_data.key_x));
          kz_nxt          = CB'($unsigned(in_data.key_z));
          cap_nxt         = (in_data.drain_limit > MAX_RESULTS) ? MAX_RESULTS
                                                                : in_data.drain_limit;
          idx_nxt         = '0;
          free_found_nxt  = 1'b0;
          cnt_nxt         = '0;
          em_nxt          = '0;
          res_status_nxt  = ST_OK;
          res_x_nxt       = '0;
          res_z_nxt       = '0;
          res_present_nxt = 1'b0;
          res_last_nxt    = 1'b1;
          case (in_data.op)
            OP_REQUEST: begin
              if (key_bad) begin
                res_status_nxt = ST_INVALID;
                state_nxt      = S_EMIT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_REMOVE: state_nxt = S_SCAN;
            OP_DRAIN: begin
              if (in_data.drain_limit == '0) begin
                res_status_nxt = ST_INVALID;
                state_nxt      = S_EMIT;
              end else begin
                state_nxt = S_COUNT;
              end
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end

      S_SCAN: begin
        if (idx_r == lim) begin
          if (op_r == OP_REQUEST) begin
            if (free_found_r) begin
              ram_we                 = 1'b1;
              busy_nxt[free_idx_r]   = 1'b1;
              pending_nxt            = pending_r + SW'(1);
              queued_nxt             = queued_r + 32'd1;
            end else begin
              drop_nxt       = drop_r + 32'd1;
              res_status_nxt = ST_FULL;
            end
          end
          state_nxt = S_EMIT;
        end else if (busy_r[slot]) begin
          ram_re    = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          if (op_r == OP_REQUEST && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = slot;
          end
          idx_nxt = idx_r + SW'(1);
        end
      end

      S_CHECK: begin
        if (ram_rdata == {kx_r, kz_r}) begin
          if (op_r == OP_REQUEST) begin
            coal_nxt = coal_r + 32'd1;
          end else begin
            busy_nxt[slot]  = 1'b0;
            pending_nxt     = (pending_r != '0) ? pending_r - SW'(1) : pending_r;
            res_x_nxt       = coord_out(kx_r);
            res_z_nxt       = coord_out(kz_r);
            res_present_nxt = 1'b1;
          end
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = idx_r + SW'(1);
          state_nxt = S_SCAN;
        end
      end

      S_COUNT: begin
        if (idx_r == lim || cnt_r == cap_r) begin
          if (cnt_r == '0) begin
            state_nxt = S_EMIT;
          end else begin
            pending_nxt = (int'(pending_r) >= int'(cnt_r)) ? SW'(int'(pending_r) - int'(cnt_r))
                                                         : '0;
            idx_nxt     = '0;
            state_nxt   = S_DSCAN;
          end
        end else begin
          if (busy_r[slot]) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          idx_nxt = idx_r + SW'(1);
        end
      end

      S_DSCAN: begin
        if (busy_r[slot]) begin
          ram_re    = 1'b1;
          state_nxt = S_DREAD;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end

      S_DREAD: begin
        busy_nxt[slot]  = 1'b0;
        res_status_nxt  = ST_OK;
        res_x_nxt       = coord_out(ram_rdata[2*CB-1:CB]);
        res_z_nxt       = coord_out(ram_rdata[CB-1:0]);
        res_present_nxt = 1'b1;
        res_last_nxt    = (CNT_W'(em_r + CNT_W'(1)) == cnt_r);
        em_nxt          = em_r + CNT_W'(1);
        idx_nxt         = idx_r + SW'(1);
        state_nxt       = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.status          = res_status_r;
          out_data_nxt.out_x           = res_x_r;
          out_data_nxt.out_z           = res_z_r;
          out_data_nxt.key_present     = res_present_r;
          out_data_nxt.last            = res_last_r;
          out_data_nxt.pending_total   = 7'(pending_r);
          out_data_nxt.queued_total    = queued_r;
          out_data_nxt.coalesced_total = coal_r;
          out_data_nxt.dropped_total   = drop_r;
          state_nxt                    = res_last_r ? S_IDLE : S_DSCAN;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pending_r) <= TABLE_SLOTS)
    else $error("pending count above table size");

  a_write_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN && free_found_r && !busy_r[free_idx_r]))
    else $error("key store written without a free slot");

  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DREAD) |-> busy_r[slot])
    else $error("drain read of an idle slot");

  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSCAN) |-> (em_r < cnt_r && idx_r < lim))
    else $error("drain scan past its count");

  a_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while busy");
`endif

endmodule

`default_nettype wire

/* tb/sv/crt_table_model_pkg.sv */
// Behavioral model of the coalescing request table and its result checker.
// Depends on crt_pkg for the beat types, op codes, status codes and register indexes.

package crt_table_model_pkg;

  import crt_pkg::*;

  localparam int TABLE_N = 64;

  class request_table_model;

    logic [6:0]  active_slots;
    logic [14:0] grid_width;
    logic [14:0] grid_depth;

    bit          busy [TABLE_N];
    logic [15:0] slot_kx [TABLE_N];
    logic [15:0] slot_kz [TABLE_N];
    int          pending;
    logic [31:0] queued;
    logic [31:0] coalesced;
    logic [31:0] dropped;

    crt_out_t    results_owed [$];
    int          fails;
    int          reported;

    function new();
      active_slots = 7'd64;
      grid_width   = 15'd256;
      grid_depth   = 15'd256;
      foreach (busy[i]) busy[i] = 1'b0;
      pending   = 0;
      queued    = '0;
      coalesced = '0;
      dropped   = '0;
      fails     = 0;
      reported  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [14:0] val);
      case (idx)
        CFG_ACTIVE_SLOTS: active_slots = val[6:0];
        CFG_GRID_WIDTH:   grid_width = val;
        CFG_GRID_DEPTH:   grid_depth = val;
        default: ;
      endcase
    endfunction

    function int slot_limit();
      return (int'(active_slots) > TABLE_N) ? TABLE_N : int'(active_slots);
    endfunction

    function int find_slot(logic [15:0] kx, logic [15:0] kz);
      int lim;
      lim = slot_limit();
      for (int i = 0; i < lim; i++) begin
        if (busy[i] && slot_kx[i] == kx && slot_kz[i] == kz) return i;
      end
      return -1;
    endfunction

    function int owed();
      return results_owed.size();
    endfunction

    // Update the table for one accepted beat and queue the results it produces.
    function void apply_beat(crt_in_t b);
      crt_out_t beats [$];
      crt_out_t r;
      int       lim;
      int       idx;
      int       xs;
      int       zs;
      lim = slot_limit();
      r = '0;
      case (b.op)
        OP_REQUEST: begin
          xs = $signed(b.key_x);
          zs = $signed(b.key_z);
          if (xs < 0 || zs < 0 || xs >= int'(grid_width) || zs >= int'(grid_depth)) begin
            r.status = ST_INVALID;
          end else if (find_slot(b.key_x, b.key_z) >= 0) begin
            coalesced++;
            r.status = ST_OK;
          end else begin
            idx = -1;
            for (int i = 0; i < lim; i++) begin
              if (!busy[i]) begin
                idx = i;
                break;
              end
            end
            if (idx >= 0) begin
              busy[idx] = 1'b1;
              slot_kx[idx] = b.key_x;
              slot_kz[idx] = b.key_z;
              pending++;
              queued++;
              r.status = ST_OK;
            end else begin
              dropped++;
              r.status = ST_FULL;
            end
          end
          beats.push_back(r);
        end
        OP_REMOVE: begin
          idx = find_slot(b.key_x, b.key_z);
          if (idx >= 0) begin
            busy[idx] = 1'b0;
            if (pending > 0) pending--;
            r.out_x = b.key_x;
            r.out_z = b.key_z;
            r.key_present = 1'b1;
          end
          beats.push_back(r);
        end
        OP_DRAIN: begin
          if (b.drain_limit == '0) begin
            r.status = ST_INVALID;
            beats.push_back(r);
          end else begin
            for (int i = 0; i < lim; i++) begin
              if (beats.size() >= int'(b.drain_limit) || beats.size() >= int'(MAX_RESULTS)) break;
              if (busy[i]) begin
                busy[i] = 1'b0;
                if (pending > 0) pending--;
                r.out_x = slot_kx[i];
                r.out_z = slot_kz[i];
                r.key_present = 1'b1;
                beats.push_back(r);
              end
            end
            if (beats.size() == 0) begin
              r = '0;
              beats.push_back(r);
            end
          end
        end
        default: beats.push_back(r);
      endcase
      foreach (beats[k]) begin
        beats[k].last            = (k == beats.size() - 1);
        beats[k].pending_total   = 7'(pending);
        beats[k].queued_total    = queued;
        beats[k].coalesced_total = coalesced;
        beats[k].dropped_total   = dropped;
        results_owed.push_back(beats[k]);
      end
    endfunction

    function string show(crt_out_t r);
      return $sformatf("st=%0d x=%0d z=%0d kp=%0b last=%0b pend=%0d q=%0d c=%0d d=%0d",
                       r.status, $signed(r.out_x), $signed(r.out_z), r.key_present, r.last,
                       r.pending_total, r.queued_total, r.coalesced_total, r.dropped_total);
    endfunction

    function void compare_result(crt_out_t got);
      crt_out_t want;
      bit       bad;
      if (results_owed.size() == 0) begin
        fails++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result beat: %s", show(got));
        end
        return;
      end
      want = results_owed.pop_front();
      bad = (got.status !== want.status) || (got.out_x !== want.out_x) ||
            (got.out_z !== want.out_z) || (got.key_present !== want.key_present) ||
            (got.last !== want.last) || (got.pending_total !== want.pending_total) ||
            (got.queued_total !== want.queued_total) ||
            (got.coalesced_total !== want.coalesced_total) ||
            (got.dropped_total !== want.dropped_total);
      if (bad) begin
        fails++;
        if (reported < 10) begin
          reported++;
          $display("result mismatch\n  exp: %s\n  act: %s", show(want), show(got));
        end
      end
    endfunction

  endclass

endpackage

/* tb/sv/testbench.sv */
// Self-checking testbench for coalescing_request_table_top: directed and random beats,
// random idling on both channels, config phases. Depends on crt_pkg and crt_table_model_pkg.

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import crt_pkg::*;
  import crt_table_model_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_BEATS = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ACTIVE_SLOTS;
  logic [14:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  crt_in_t     in_data = '0;
  logic        in_stall;
  logic        out_valid;
  crt_out_t    out_data;
  logic        out_stall = 1'b0;

  request_table_model tbl;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int ph_slots [NUM_PHASES] = '{4, 64, 1, 0, 127, 7, 16, 64};
  int ph_width [NUM_PHASES] = '{8, 16, 1, 8, 32767, 0, 3, 256};
  int ph_depth [NUM_PHASES] = '{8, 4, 1, 8, 32767, 5, 0, 256};
  int ph_pool  [NUM_PHASES] = '{6, 6, 3, 6, 6, 6, 6, 8};

  coalescing_request_table_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tbl.compare_result(out_data);
  end

  task automatic send(crt_in_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    tbl.apply_beat(b);
  endtask

  task automatic offer(crt_op_t op, int x, int z, int dl);
    crt_in_t b;
    b = '0;
    b.op = op;
    b.key_x = 16'(x);
    b.key_z = 16'(z);
    b.drain_limit = 7'(dl);
    send(b);
  endtask

  // stop offering and wait for every outstanding result beat
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (tbl.owed() != 0);
  endtask

  task automatic cfg_write(logic [1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 15'(val);
    do @(posedge clk); while (!cfg_ready);
    tbl.write_reg(idx, 15'(val));
  endtask

  task automatic set_table(int slots, int width, int depth);
    cfg_write(CFG_ACTIVE_SLOTS, slots);
    cfg_write(CFG_GRID_WIDTH, width);
    cfg_write(CFG_GRID_DEPTH, depth);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_coord(int pool, int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, pool - 1));
    if (r < 78) return 16'(span - 1);
    if (r < 84) return 16'(span);
    return 16'($urandom);
  endfunction

  function automatic crt_in_t rand_beat(int pool);
    crt_in_t b;
    int      r;
    b = '0;
    r = $urandom_range(0, 99);
    if (r < 45) b.op = OP_REQUEST;
    else if (r < 65) b.op = OP_REMOVE;
    else if (r < 90) b.op = OP_DRAIN;
    else b.op = OP_READ;
    b.key_x = rand_coord(pool, int'(tbl.grid_width));
    b.key_z = rand_coord(pool, int'(tbl.grid_depth));
    r = $urandom_range(0, 99);
    if (r < 20) b.drain_limit = '0;
    else if (r < 70) b.drain_limit = 7'($urandom_range(1, 4));
    else b.drain_limit = 7'($urandom);
    return b;
  endfunction

  task automatic directed_beats();
    offer(OP_READ, 0, 0, 0);
    offer(OP_DRAIN, 0, 0, 0);
    offer(OP_DRAIN, 0, 0, 5);
    offer(OP_REQUEST, 0, 0, 0);
    offer(OP_REQUEST, 255, 255, 0);
    offer(OP_REQUEST, 256, 0, 0);
    offer(OP_REQUEST, 0, 256, 0);
    offer(OP_REQUEST, -1, 0, 0);
    offer(OP_REQUEST, 0, -32768, 0);
    offer(OP_REQUEST, 32767, -1, 0);
    offer(OP_REQUEST, 0, 0, 0);
    offer(OP_REMOVE, 5, 5, 0);
    offer(OP_REMOVE, -32768, 32767, 127);
    offer(OP_REQUEST, 10, 20, 0);
    offer(OP_REQUEST, 3, 4, 0);
    offer(OP_REMOVE, 255, 255, 0);
    offer(OP_DRAIN, 0, 0, 1);
    offer(OP_DRAIN, 0, 0, 127);
    offer(OP_READ, 0, 0, 0);
  endtask

  task automatic run_phase(int p);
    int mode;
    mode = p % 4;
    quiesce();
    set_table(ph_slots[p], ph_width[p], ph_depth[p]);
    send_idle_pct = (mode == 1) ? 45 : (mode == 3) ? 20 : 0;
    stall_pct = (mode == 2) ? 45 : (mode == 3) ? 20 : 0;
    if (p == 0) hold_token++;
    if (p == 4) begin
      // fill past the 64-slot table, then one drain that hits the per-drain cap
      for (int i = 0; i < 70; i++) offer(OP_REQUEST, i, 2 * i, 0);
      offer(OP_DRAIN, 0, 0, 127);
    end
    for (int k = 0; k < PHASE_BEATS; k++) begin
      if (p == 5 && k == PHASE_BEATS / 2) quiesce();
      send(rand_beat(ph_pool[p]));
    end
  endtask

  initial begin
    tbl = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    directed_beats();
    for (int p = 0; p < NUM_PHASES; p++) run_phase(p);
    quiesce();
    repeat (HOLD_CYCLES) @(posedge clk);
    if (tbl.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/crt_pkg.sv
hw/rtl/crt_ram.sv
hw/rtl/crt_seq.sv
hw/rtl/coalescing_request_table_top.sv
tb/sv/crt_table_model_pkg.sv
tb/sv/testbench.sv
